// ===== src/assert_macros.svh =====
// Assertion macros shared by the handle allocator RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define HSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define HSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hsa_pkg.sv =====
// Package for the handle slot allocator: codes, sizes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 256;
  localparam int unsigned DEFER_DEPTH_DEF = 64;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned UID_W   = 31;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned STAT_W  = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEFER  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd5;

  // result codes
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // slot table entry
  typedef struct packed {
    logic             occ;
    logic [UID_W-1:0] uid;
    logic [TAG_W-1:0] tag;
  } slot_entry_t;

  // queued operation; only add, remove and clear are queued
  typedef struct packed {
    logic [1:0]         op;
    logic [INDEX_W-1:0] index;
    logic [UID_W-1:0]   uid;
    logic [TAG_W-1:0]   tag;
  } defer_entry_t;

endpackage

`default_nettype wire

// ===== src/hsa_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on hsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [hsa_pkg::MODE_W-1:0]   mode;
  logic [hsa_pkg::INDEX_W-1:0]  handle_index;
  logic [hsa_pkg::UID_W-1:0]    handle_uid;
  logic [hsa_pkg::TAG_W-1:0]    entry_tag;

  modport source (output valid, mode, handle_index, handle_uid, entry_tag, input ready);
  modport sink   (input valid, mode, handle_index, handle_uid, entry_tag, output ready);
endinterface

interface hsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [hsa_pkg::STAT_W-1:0]   status;
  logic [hsa_pkg::INDEX_W-1:0]  granted_index;
  logic [hsa_pkg::UID_W-1:0]    granted_uid;
  logic [hsa_pkg::TAG_W-1:0]    found_tag;
  logic                         last_result;

  modport source (output valid, status, granted_index, granted_uid, found_tag, last_result,
                  input ready);
  modport sink   (input valid, status, granted_index, granted_uid, found_tag, last_result,
                  output ready);
endinterface

`default_nettype wire

// ===== src/handle_slot_allocator_deferred_unit.sv =====
// Handle slot allocator with deferred add/remove/clear queue.
// Depends on hsa_pkg, hsa_if.sv and assert_macros.svh.
//
//  channel | dir | handshake          | word
//  in_ch   | in  | valid/ready        | mode, handle_index, handle_uid, entry_tag
//  out_ch  | out | valid/ready        | status, granted_index, granted_uid, found_tag, last_result
//
// Each operation first reads the slot table and free list, then modifies, writes back
// and loads the output register.
// Flush replays each queued operation in turn (queue read, then table access).
// No clearing pass after reset; the list length guards table reads.
// A full output register holds the block in its write-back cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module handle_slot_allocator_deferred_unit #(
  parameter int unsigned SLOT_COUNT  = hsa_pkg::SLOT_COUNT_DEF,
  parameter int unsigned DEFER_DEPTH = hsa_pkg::DEFER_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  hsa_in_if.sink    in_ch,
  hsa_out_if.source out_ch
);

  localparam int unsigned IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned DW  = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(DEFER_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DQ} state_t;

  state_t state_r, state_nxt;

  logic [hsa_pkg::MODE_W-1:0]  op_mode_r, op_mode_nxt;
  logic [hsa_pkg::INDEX_W-1:0] op_idx_r, op_idx_nxt;
  logic [hsa_pkg::UID_W-1:0]   op_uid_r, op_uid_nxt;
  logic [hsa_pkg::TAG_W-1:0]   op_tag_r, op_tag_nxt;
  logic                        replay_r, replay_nxt;
  logic                        op_last_r, op_last_nxt;

  logic [CW-1:0]              list_len_r, list_len_nxt;
  logic [IW-1:0]              free_head_r, free_head_nxt;
  logic [CW-1:0]              free_cnt_r, free_cnt_nxt;
  logic [hsa_pkg::UID_W-1:0]  next_uid_r, next_uid_nxt;
  logic                       deferring_r, deferring_nxt;
  logic [DW-1:0]              dq_head_r, dq_head_nxt;
  logic [QCW-1:0]             dq_cnt_r, dq_cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [hsa_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [hsa_pkg::INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [hsa_pkg::UID_W-1:0]    out_uid_r, out_uid_nxt;
  logic [hsa_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                         out_last_r, out_last_nxt;

  // memories
  hsa_pkg::slot_entry_t  slot_mem [SLOT_COUNT];
  logic [IW-1:0]         free_mem [SLOT_COUNT];
  hsa_pkg::defer_entry_t dq_mem   [DEFER_DEPTH];

  hsa_pkg::slot_entry_t  slot_q_r, slot_wd;
  logic [IW-1:0]         free_q_r, free_wd;
  hsa_pkg::defer_entry_t dq_q_r, dq_wd;

  logic          slot_rd_en, slot_we, free_rd_en, free_we, dq_rd_en, dq_we;
  logic [IW-1:0] slot_rd_addr, slot_wa, free_wa;
  logic [DW-1:0] dq_wa;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_rd_en) slot_q_r <= slot_mem[slot_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (free_rd_en) free_q_r <= free_mem[free_head_r];
  end

  always_ff @(posedge clk) begin
    if (dq_we) dq_mem[dq_wa] <= dq_wd;
    if (dq_rd_en) dq_q_r <= dq_mem[dq_head_r];
  end

  logic in_fire, out_free, slot_ok;
  logic [CW:0]  free_tail_sum;
  logic [QCW:0] dq_tail_sum;
  logic [IW-1:0] new_slot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // handles past the list end were never written since the last clear
  assign slot_ok = (32'(op_idx_r) < 32'(list_len_r)) && slot_q_r.occ &&
                   (slot_q_r.uid == op_uid_r);

  assign free_tail_sum = (CW+1)'(free_head_r) + (CW+1)'(free_cnt_r);
  assign dq_tail_sum   = (QCW+1)'(dq_head_r) + (QCW+1)'(dq_cnt_r);

  always_comb begin
    state_nxt      = state_r;
    op_mode_nxt    = op_mode_r;
    op_idx_nxt     = op_idx_r;
    op_uid_nxt     = op_uid_r;
    op_tag_nxt     = op_tag_r;
    replay_nxt     = replay_r;
    op_last_nxt    = op_last_r;
    list_len_nxt   = list_len_r;
    free_head_nxt  = free_head_r;
    free_cnt_nxt   = free_cnt_r;
    next_uid_nxt   = next_uid_r;
    deferring_nxt  = deferring_r;
    dq_head_nxt    = dq_head_r;
    dq_cnt_nxt     = dq_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_uid_nxt    = out_uid_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;

    slot_rd_en   = 1'b0;
    slot_rd_addr = IW'(in_ch.handle_index);
    slot_we      = 1'b0;
    slot_wa      = IW'(op_idx_r);
    slot_wd      = slot_q_r;
    free_rd_en   = 1'b0;
    free_we      = 1'b0;
    free_wa      = '0;
    free_wd      = IW'(op_idx_r);
    dq_rd_en     = 1'b0;
    dq_we        = 1'b0;
    dq_wa        = '0;
    dq_wd        = '{op: op_mode_r[1:0], index: op_idx_r, uid: op_uid_r, tag: op_tag_r};
    new_slot     = free_q_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_mode_nxt = in_ch.mode;
          op_idx_nxt  = in_ch.handle_index;
          op_uid_nxt  = in_ch.handle_uid;
          op_tag_nxt  = in_ch.entry_tag;
          replay_nxt  = 1'b0;
          op_last_nxt = 1'b1;
          slot_rd_en  = 1'b1;
          free_rd_en  = 1'b1;
          state_nxt   = S_RUN;
        end
      end

      S_DQ: begin
        op_mode_nxt = {1'b0, dq_q_r.op};
        op_idx_nxt  = dq_q_r.index;
        op_uid_nxt  = dq_q_r.uid;
        op_tag_nxt  = dq_q_r.tag;
        op_last_nxt = (dq_cnt_r == QCW'(1));
        dq_head_nxt = (dq_head_r == DW'(DEFER_DEPTH - 1)) ? '0 : dq_head_r + DW'(1);
        dq_cnt_nxt  = dq_cnt_r - QCW'(1);
        slot_rd_addr = IW'(dq_q_r.index);
        slot_rd_en  = 1'b1;
        free_rd_en  = 1'b1;
        state_nxt   = S_RUN;
      end

      S_RUN: begin
        if (op_mode_r == hsa_pkg::MODE_FLUSH && deferring_r && dq_cnt_r != '0) begin
          // start the replay; the queued ops make the results
          replay_nxt = 1'b1;
          dq_rd_en   = 1'b1;
          state_nxt  = S_DQ;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hsa_pkg::ST_DONE;
          out_index_nxt  = '0;
          out_uid_nxt    = '0;
          out_tag_nxt    = '0;
          out_last_nxt   = op_last_r;
          state_nxt      = S_IDLE;

          if (!replay_r && deferring_r && op_mode_r <= hsa_pkg::MODE_CLEAR) begin
            if (dq_cnt_r == QCW'(DEFER_DEPTH)) begin
              out_status_nxt = hsa_pkg::ST_FULL;
            end else begin
              dq_we          = 1'b1;
              dq_wa          = (dq_tail_sum >= (QCW+1)'(DEFER_DEPTH)) ?
                               DW'(dq_tail_sum - (QCW+1)'(DEFER_DEPTH)) : DW'(dq_tail_sum);
              dq_cnt_nxt     = dq_cnt_r + QCW'(1);
              out_status_nxt = hsa_pkg::ST_QUEUED;
            end
          end else begin
            case (op_mode_r)
              hsa_pkg::MODE_ADD: begin
                if (free_cnt_r != '0 || list_len_r != CW'(SLOT_COUNT)) begin
                  if (free_cnt_r != '0) begin
                    new_slot      = free_q_r;
                    free_head_nxt = (free_head_r == IW'(SLOT_COUNT - 1)) ? '0 :
                                    free_head_r + IW'(1);
                    free_cnt_nxt  = free_cnt_r - CW'(1);
                  end else begin
                    new_slot     = IW'(list_len_r);
                    list_len_nxt = list_len_r + CW'(1);
                  end
                  slot_we       = 1'b1;
                  slot_wa       = new_slot;
                  slot_wd       = '{occ: 1'b1, uid: next_uid_r, tag: op_tag_r};
                  next_uid_nxt  = next_uid_r + hsa_pkg::UID_W'(1);
                  out_index_nxt = hsa_pkg::INDEX_W'(new_slot);
                  out_uid_nxt   = next_uid_r;
                  out_tag_nxt   = op_tag_r;
                end else begin
                  out_status_nxt = hsa_pkg::ST_FULL;
                end
              end
              hsa_pkg::MODE_REMOVE: begin
                out_index_nxt = op_idx_r;
                out_uid_nxt   = op_uid_r;
                if (slot_ok && free_cnt_r != CW'(SLOT_COUNT)) begin
                  slot_we      = 1'b1;
                  slot_wd.occ  = 1'b0;
                  free_we      = 1'b1;
                  free_wa      = (free_tail_sum >= (CW+1)'(SLOT_COUNT)) ?
                                 IW'(free_tail_sum - (CW+1)'(SLOT_COUNT)) : IW'(free_tail_sum);
                  free_cnt_nxt = free_cnt_r + CW'(1);
                end else begin
                  out_status_nxt = hsa_pkg::ST_NOTFOUND;
                end
              end
              hsa_pkg::MODE_CLEAR: begin
                list_len_nxt  = '0;
                free_head_nxt = '0;
                free_cnt_nxt  = '0;
              end
              hsa_pkg::MODE_LOOKUP: begin
                out_index_nxt = op_idx_r;
                out_uid_nxt   = op_uid_r;
                if (slot_ok) out_tag_nxt = slot_q_r.tag;
                else out_status_nxt = hsa_pkg::ST_NOTFOUND;
              end
              hsa_pkg::MODE_DEFER: begin
                deferring_nxt = 1'b1;
              end
              hsa_pkg::MODE_FLUSH: begin
                deferring_nxt = 1'b0;
                dq_head_nxt   = '0;
                dq_cnt_nxt    = '0;
              end
              default: begin
              end
            endcase
          end

          if (replay_r) begin
            if (op_last_r) begin
              deferring_nxt = 1'b0;
              dq_head_nxt   = '0;
              dq_cnt_nxt    = '0;
              replay_nxt    = 1'b0;
            end else begin
              dq_rd_en  = 1'b1;
              state_nxt = S_DQ;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      replay_r    <= 1'b0;
      list_len_r  <= '0;
      free_head_r <= '0;
      free_cnt_r  <= '0;
      next_uid_r  <= '0;
      deferring_r <= 1'b0;
      dq_head_r   <= '0;
      dq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      replay_r    <= replay_nxt;
      list_len_r  <= list_len_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      next_uid_r  <= next_uid_nxt;
      deferring_r <= deferring_nxt;
      dq_head_r   <= dq_head_nxt;
      dq_cnt_r    <= dq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_mode_r    <= op_mode_nxt;
    op_idx_r     <= op_idx_nxt;
    op_uid_r     <= op_uid_nxt;
    op_tag_r     <= op_tag_nxt;
    op_last_r    <= op_last_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_uid_r    <= out_uid_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_index = out_index_r;
  assign out_ch.granted_uid   = out_uid_r;
  assign out_ch.found_tag     = out_tag_r;
  assign out_ch.last_result   = out_last_r;

  `HSA_ASSERT(a_accept_runs, in_fire |=> state_r == S_RUN, "accepted word did not start")
  `HSA_ASSERT(a_free_bound, free_cnt_r <= list_len_r, "free count beyond list length")
  `HSA_ASSERT(a_len_bound, list_len_r <= CW'(SLOT_COUNT), "list length beyond table")
  `HSA_ASSERT(a_dq_bound, dq_cnt_r <= QCW'(DEFER_DEPTH), "deferred queue overfilled")
  `HSA_ASSERT(a_replay_defer, replay_r |-> deferring_r, "replay without deferral")

endmodule

`default_nettype wire
